@@ hw/rtl/frame_stream_receiver_defines.svh @@
// assertion macros for the frame stream receiver checker
`ifndef FRAME_STREAM_RECEIVER_DEFINES_SVH
`define FRAME_STREAM_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsr check failed");

// next-cycle implication, sampled on clk, off during rst
`define FSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsr check failed");

`endif

@@ hw/rtl/fsr_pkg.sv @@
// shared types, codes and tables for the frame stream receiver
package fsr_pkg;

  localparam int CFG_W       = 10;
  localparam int MAX_CTL_RST = 512;
  localparam int ID_LEN      = 22;
  localparam int REPLY_LEN   = 42;
  localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  localparam logic [2:0] EV_READY_HIT  = 3'd0;
  localparam logic [2:0] EV_READY_MISS = 3'd1;
  localparam logic [2:0] EV_START_HIT  = 3'd2;
  localparam logic [2:0] EV_START_MISS = 3'd3;
  localparam logic [2:0] EV_STOP       = 3'd4;
  localparam logic [2:0] EV_UNKNOWN    = 3'd5;
  localparam logic [2:0] EV_LEN_ERR    = 3'd6;

  localparam logic [31:0] CT_READY = 32'd4;
  localparam logic [31:0] CT_START = 32'd2;
  localparam logic [31:0] CT_STOP  = 32'd3;
  localparam logic [31:0] FT_CONTENT = 32'd1;

  typedef enum logic [3:0] {
    PH_LEN   = 4'd0,
    PH_CLEN  = 4'd1,
    PH_CTYPE = 4'd2,
    PH_FTYPE = 4'd3,
    PH_FLEN  = 4'd4,
    PH_BODY  = 4'd5,
    PH_SKIP  = 4'd6,
    PH_DATA  = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    MS_SEARCH = 2'd0,
    MS_MATCH  = 2'd1,
    MS_FAIL   = 2'd2
  } match_t;

  typedef enum logic [2:0] {
    CK_OTHER = 3'd0,
    CK_READY = 3'd1,
    CK_START = 3'd2,
    CK_STOP  = 3'd3
  } ctl_kind_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] code;
    logic       started;
    logic       reply;
  } fsr_res_t;

  function automatic logic [7:0] fsr_id_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h70;
      5'd1:    b = 8'h72;
      5'd2:    b = 8'h6f;
      5'd3:    b = 8'h74;
      5'd4:    b = 8'h6f;
      5'd5:    b = 8'h62;
      5'd6:    b = 8'h75;
      5'd7:    b = 8'h66;
      5'd8:    b = 8'h3a;
      5'd9:    b = 8'h64;
      5'd10:   b = 8'h6e;
      5'd11:   b = 8'h73;
      5'd12:   b = 8'h74;
      5'd13:   b = 8'h61;
      5'd14:   b = 8'h70;
      5'd15:   b = 8'h2e;
      5'd16:   b = 8'h44;
      5'd17:   b = 8'h6e;
      5'd18:   b = 8'h73;
      5'd19:   b = 8'h74;
      5'd20:   b = 8'h61;
      5'd21:   b = 8'h70;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fsr_reply_byte(input logic [REPLY_IDX_W-1:0] idx);
    logic [REPLY_IDX_W-1:0] off;
    logic [7:0] b;
    off = idx - REPLY_IDX_W'(REPLY_LEN - ID_LEN);
    if (idx >= REPLY_IDX_W'(REPLY_LEN - ID_LEN)) begin
      b = fsr_id_byte(off[4:0]);
    end else begin
      case (idx)
        REPLY_IDX_W'(7):  b = 8'd34;
        REPLY_IDX_W'(11): b = 8'd1;
        REPLY_IDX_W'(15): b = 8'd1;
        REPLY_IDX_W'(19): b = 8'd22;
        default:          b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage

@@ hw/rtl/fsr_in_if.sv @@
// byte stream channel into the receiver
interface fsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/fsr_out_if.sv @@
// result channel out of the receiver
interface fsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  logic [2:0] event_code;
  logic       started_now;

  modport source (output valid, output kind, output out_byte, output last,
                  output event_code, output started_now, input ready);
  modport sink   (input valid, input kind, input out_byte, input last,
                  input event_code, input started_now, output ready);
endinterface

@@ hw/rtl/fsr_parser.sv @@
// framing parser: length words, control frame fields and data bytes
module fsr_parser import fsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic [CFG_W-1:0] max_len,
  output fsr_res_t         res,
  output logic             started
);

  phase_t      phase, phase_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] bytes_left, bytes_left_next;
  ctl_kind_t   control_kind, control_kind_next;
  logic [9:0]  field_left, field_left_next;
  logic [4:0]  id_index, id_index_next;
  match_t      match_status, match_status_next;
  logic        stream_started, stream_started_next;
  logic        halted, halted_next;
  logic        id_equal, id_equal_next;

  logic [31:0] w;
  logic [4:0]  cnt1;
  logic        full;
  logic        fin;
  logic        want_next;
  logic        hit;

  assign w    = {word_shift[23:0], rx_byte};
  assign cnt1 = id_index + 5'd1;
  assign full = (cnt1 >= 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      word_shift     <= '0;
      bytes_left     <= '0;
      control_kind   <= CK_OTHER;
      field_left     <= '0;
      id_index       <= '0;
      match_status   <= MS_SEARCH;
      stream_started <= 1'b0;
      halted         <= 1'b0;
      id_equal       <= 1'b0;
    end else begin
      phase          <= phase_next;
      word_shift     <= word_shift_next;
      bytes_left     <= bytes_left_next;
      control_kind   <= control_kind_next;
      field_left     <= field_left_next;
      id_index       <= id_index_next;
      match_status   <= match_status_next;
      stream_started <= stream_started_next;
      halted         <= halted_next;
      id_equal       <= id_equal_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    word_shift_next     = word_shift;
    bytes_left_next     = bytes_left;
    control_kind_next   = control_kind;
    field_left_next     = field_left;
    id_index_next       = id_index;
    match_status_next   = match_status;
    stream_started_next = stream_started;
    halted_next         = halted;
    id_equal_next       = id_equal;
    res                 = '0;
    fin                 = 1'b0;
    want_next           = 1'b0;
    hit                 = 1'b0;

    if (fire && !halted) begin
      case (phase)
        PH_LEN: begin
          word_shift_next = w;
          id_index_next   = cnt1;
          if (full) begin
            id_index_next   = '0;
            word_shift_next = '0;
            if (w == 32'd0) begin
              phase_next = PH_CLEN;
            end else begin
              bytes_left_next = w;
              phase_next      = PH_DATA;
            end
          end
        end
        PH_CLEN: begin
          word_shift_next = w;
          id_index_next   = cnt1;
          if (full) begin
            id_index_next = '0;
            if (w < 32'd4 || w > {22'd0, max_len}) begin
              halted_next = 1'b1;
              res.valid   = 1'b1;
              res.kind    = KIND_EVENT;
              res.code    = EV_LEN_ERR;
            end else begin
              bytes_left_next = w - 32'd4;
              word_shift_next = '0;
              phase_next      = PH_CTYPE;
            end
          end
        end
        PH_CTYPE: begin
          word_shift_next = w;
          id_index_next   = cnt1;
          if (full) begin
            id_index_next     = '0;
            word_shift_next   = '0;
            match_status_next = MS_SEARCH;
            if (w == CT_READY) begin
              control_kind_next = CK_READY;
            end else if (w == CT_START) begin
              control_kind_next = CK_START;
            end else if (w == CT_STOP) begin
              control_kind_next = CK_STOP;
            end else begin
              control_kind_next = CK_OTHER;
            end
            if (bytes_left == 32'd0) begin
              fin = 1'b1;
            end else begin
              want_next = 1'b1;
            end
          end
        end
        PH_DATA: begin
          bytes_left_next = bytes_left - 32'd1;
          if (bytes_left_next == 32'd0) begin
            phase_next = PH_LEN;
          end
          if (stream_started) begin
            res.valid = 1'b1;
            res.kind  = KIND_DATA;
            res.data  = rx_byte;
            res.last  = (bytes_left_next == 32'd0);
          end
        end
        default: begin
          // control payload byte
          if (bytes_left != 32'd0) begin
            bytes_left_next = bytes_left - 32'd1;
          end
          case (phase)
            PH_FTYPE: begin
              word_shift_next = w;
              id_index_next   = cnt1;
              if (full) begin
                id_index_next   = '0;
                word_shift_next = '0;
                if (w != FT_CONTENT) begin
                  match_status_next = MS_FAIL;
                  phase_next        = PH_SKIP;
                end else begin
                  phase_next = PH_FLEN;
                end
              end
            end
            PH_FLEN: begin
              word_shift_next = w;
              id_index_next   = cnt1;
              if (full) begin
                id_index_next   = '0;
                word_shift_next = '0;
                if (w > bytes_left_next) begin
                  match_status_next = MS_FAIL;
                  phase_next        = PH_SKIP;
                end else begin
                  field_left_next = w[9:0];
                  id_equal_next   = (w == 32'(ID_LEN));
                  if (w == 32'd0) begin
                    want_next = 1'b1;
                  end else begin
                    phase_next = PH_BODY;
                  end
                end
              end
            end
            PH_BODY: begin
              if (id_equal) begin
                if (id_index < 5'(ID_LEN) && rx_byte == fsr_id_byte(id_index)) begin
                  id_index_next = id_index + 5'd1;
                end else begin
                  id_equal_next = 1'b0;
                end
              end
              if (field_left != 10'd0) begin
                field_left_next = field_left - 10'd1;
              end
              if (field_left_next == 10'd0) begin
                if (id_equal_next) begin
                  match_status_next = MS_MATCH;
                  phase_next        = PH_SKIP;
                end else begin
                  want_next = 1'b1;
                end
              end
            end
            default: begin
              phase_next = PH_SKIP;
            end
          endcase
          if (bytes_left_next == 32'd0) begin
            fin = 1'b1;
          end
        end
      endcase

      if (fin) begin
        phase_next      = PH_LEN;
        word_shift_next = '0;
        id_index_next   = '0;
        hit             = (match_status_next == MS_MATCH);
        res.valid       = 1'b1;
        res.kind        = KIND_EVENT;
        case (control_kind_next)
          CK_READY: begin
            res.code  = hit ? EV_READY_HIT : EV_READY_MISS;
            res.reply = hit;
          end
          CK_START: begin
            if (hit) begin
              stream_started_next = 1'b1;
            end
            res.code = hit ? EV_START_HIT : EV_START_MISS;
          end
          CK_STOP: begin
            stream_started_next = 1'b0;
            res.code            = EV_STOP;
          end
          default: begin
            res.code = EV_UNKNOWN;
          end
        endcase
      end else if (want_next) begin
        id_index_next   = '0;
        word_shift_next = '0;
        phase_next      = (match_status_next == MS_SEARCH && bytes_left_next >= 32'd9)
                          ? PH_FTYPE : PH_SKIP;
      end
    end

    res.started = stream_started_next;
  end

  assign started = stream_started;

endmodule

@@ hw/rtl/fsr_out_stage.sv @@
// result register and accept reply sequencer
module fsr_out_stage import fsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  fsr_res_t         res_in,
  input  logic             started,
  output logic             in_ready,
  fsr_out_if.source        res
);

  logic                   valid;
  logic                   reply_busy;
  logic [REPLY_IDX_W-1:0] reply_idx;
  logic [1:0]             kind;
  logic [7:0]             data;
  logic                   last;
  logic [2:0]             code;
  logic                   started_now;
  logic                   out_fire;
  logic                   load_res;
  logic                   load_reply;

  assign out_fire   = valid && res.ready;
  assign in_ready   = !reply_busy && (!valid || res.ready);
  assign load_res   = in_fire && res_in.valid;
  assign load_reply = out_fire && reply_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      reply_busy <= 1'b0;
      reply_idx  <= '0;
    end else begin
      if (load_res) begin
        valid      <= 1'b1;
        reply_busy <= res_in.reply;
        reply_idx  <= '0;
      end else if (load_reply) begin
        valid     <= 1'b1;
        reply_idx <= reply_idx + 1'b1;
        if (reply_idx == REPLY_IDX_W'(REPLY_LEN - 1)) begin
          reply_busy <= 1'b0;
        end
      end else if (out_fire) begin
        valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load_res) begin
      kind        <= res_in.kind;
      data        <= res_in.data;
      last        <= res_in.last;
      code        <= res_in.code;
      started_now <= res_in.started;
    end else if (load_reply) begin
      kind        <= KIND_REPLY;
      data        <= fsr_reply_byte(reply_idx);
      last        <= (reply_idx == REPLY_IDX_W'(REPLY_LEN - 1));
      code        <= EV_READY_HIT;
      started_now <= started;
    end
  end

  assign res.valid       = valid;
  assign res.kind        = kind;
  assign res.out_byte    = data;
  assign res.last        = last;
  assign res.event_code  = code;
  assign res.started_now = started_now;

endmodule

@@ hw/rtl/frame_stream_receiver.sv @@
// Frame stream receiver top level. Takes one stream byte per beat and parses
// length-prefixed frames: data frame bytes come out with a last mark while the
// stream is started, and each control frame yields one event beat. A READY
// carrying the matching content type is followed by 42 reply beats, during
// which no input is taken, so that frame costs 43 output beats; every other
// byte is taken at one per cycle, limited only by the single result register
// that the parser and the reply sequencer share. A control length outside
// 4..max_control_len reports a length error and the block then swallows all
// input silently until reset. No clearing pass follows reset.
module frame_stream_receiver import fsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fsr_in_if.sink           rx,
  fsr_out_if.source        res,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0] max_control_len;
  logic             in_fire;
  logic             started;
  fsr_res_t         pres;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_control_len <= CFG_W'(MAX_CTL_RST);
    end else if (cfg_wr_en) begin
      max_control_len <= cfg_wr_data;
    end
  end

  assign in_fire = rx.valid && rx.ready;

  fsr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .rx_byte (rx.rx_byte),
    .max_len (max_control_len),
    .res     (pres),
    .started (started)
  );

  fsr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .res_in   (pres),
    .started  (started),
    .in_ready (rx.ready),
    .res      (res)
  );

endmodule

@@ hw/rtl/fsr_checker.sv @@
// port-level checks for the frame stream receiver, bound to the top level
`include "frame_stream_receiver_defines.svh"

module fsr_checker import fsr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       last,
  input logic [2:0] event_code,
  input logic       started_now
);

  `FSR_ASSERT_NXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(kind) && $stable(out_byte) && $stable(last) && $stable(event_code))
  `FSR_ASSERT_IMP(a_event_clean, res_valid && kind == KIND_EVENT, out_byte == 8'd0 && !last)
  `FSR_ASSERT_IMP(a_byte_no_code, res_valid && kind != KIND_EVENT, event_code == EV_READY_HIT)
  `FSR_ASSERT_IMP(a_data_started, res_valid && kind == KIND_DATA, started_now)

endmodule

bind frame_stream_receiver fsr_checker u_fsr_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .kind        (res.kind),
  .out_byte    (res.out_byte),
  .last        (res.last),
  .event_code  (res.event_code),
  .started_now (res.started_now)
);

@@ sim/frame_stream_receiver_tb.sv @@
// self-checking testbench for the frame stream receiver: directed and random byte streams
`timescale 1ns / 100ps

module frame_stream_receiver_tb;
  import fsr_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] code;
    logic       started;
  } beat_t;

  localparam logic [2:0] NO_EVENT = 3'd0;
  localparam logic [8*ID_LEN-1:0] DNSTAP_ID = "protobuf:dnstap.Dnstap";
  localparam logic [8*REPLY_LEN-1:0] ACCEPT_FRAME =
    {32'd0, 32'd34, 32'd1, 32'd1, 32'd22, DNSTAP_ID};

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic steady;
  logic hold_off;
  int run_stage;
  int fault_count;
  int stream_len;

  logic [7:0] stream_bytes_q[$];
  logic [7:0] body_q[$];
  beat_t parser_out_q[$];

  // parser model state
  phase_t ps_phase;
  logic [31:0] ps_word;
  logic [31:0] ps_left;
  logic [31:0] ps_field;
  ctl_kind_t ps_kind;
  logic [4:0] ps_idx;
  match_t ps_match;
  logic ps_started;
  logic ps_halted;
  logic ps_id_eq;
  logic [CFG_W-1:0] ps_max;

  fsr_in_if stream_in ();
  fsr_out_if result_out ();

  frame_stream_receiver uut (
    .clk(clk),
    .rst(rst),
    .rx(stream_in),
    .res(result_out),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("frame_stream_receiver: mismatch");
    $finish;
  end

  function automatic logic [7:0] dnstap_char(input int i);
    return DNSTAP_ID[8*(ID_LEN-1-i) +: 8];
  endfunction

  // ---------------- parser model ----------------

  function automatic logic word_done(input logic [7:0] b);
    ps_word = {ps_word[23:0], b};
    ps_idx = ps_idx + 5'd1;
    if (ps_idx >= 5'd4) begin
      ps_idx = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_beat(input logic [1:0] kind, input logic [7:0] data,
                           input logic last, input logic [2:0] code);
    beat_t b;
    b = {kind, data, last, code, ps_started};
    parser_out_q.push_back(b);
  endtask

  task automatic open_field();
    ps_idx = '0;
    ps_word = '0;
    ps_phase = (ps_match == MS_SEARCH && ps_left >= 9) ? PH_FTYPE : PH_SKIP;
  endtask

  task automatic close_control();
    logic hit;
    hit = (ps_match == MS_MATCH);
    ps_phase = PH_LEN;
    ps_word = '0;
    ps_idx = '0;
    case (ps_kind)
      CK_READY: begin
        push_beat(KIND_EVENT, 8'd0, 1'b0, hit ? EV_READY_HIT : EV_READY_MISS);
        if (hit) begin
          for (int i = 0; i < REPLY_LEN; i++) begin
            push_beat(KIND_REPLY, ACCEPT_FRAME[8*(REPLY_LEN-1-i) +: 8],
                      i == REPLY_LEN - 1, NO_EVENT);
          end
        end
      end
      CK_START: begin
        if (hit) ps_started = 1'b1;
        push_beat(KIND_EVENT, 8'd0, 1'b0, hit ? EV_START_HIT : EV_START_MISS);
      end
      CK_STOP: begin
        ps_started = 1'b0;
        push_beat(KIND_EVENT, 8'd0, 1'b0, EV_STOP);
      end
      default: begin
        push_beat(KIND_EVENT, 8'd0, 1'b0, EV_UNKNOWN);
      end
    endcase
  endtask

  task automatic parse_stream_byte(input logic [7:0] b);
    logic next_fld;
    next_fld = 1'b0;
    if (!ps_halted) begin
      case (ps_phase)
        PH_LEN: begin
          if (word_done(b)) begin
            if (ps_word == 0) begin
              ps_phase = PH_CLEN;
            end else begin
              ps_left = ps_word;
              ps_phase = PH_DATA;
            end
            ps_word = '0;
          end
        end
        PH_CLEN: begin
          if (word_done(b)) begin
            if (ps_word < 4 || ps_word > {22'd0, ps_max}) begin
              ps_halted = 1'b1;
              push_beat(KIND_EVENT, 8'd0, 1'b0, EV_LEN_ERR);
            end else begin
              ps_left = ps_word - 32'd4;
              ps_word = '0;
              ps_phase = PH_CTYPE;
            end
          end
        end
        PH_CTYPE: begin
          if (word_done(b)) begin
            case (ps_word)
              CT_READY: ps_kind = CK_READY;
              CT_START: ps_kind = CK_START;
              CT_STOP:  ps_kind = CK_STOP;
              default:  ps_kind = CK_OTHER;
            endcase
            ps_match = MS_SEARCH;
            if (ps_left == 0) close_control();
            else open_field();
          end
        end
        PH_DATA: begin
          ps_left = ps_left - 32'd1;
          if (ps_left == 0) ps_phase = PH_LEN;
          if (ps_started) push_beat(KIND_DATA, b, ps_left == 0, NO_EVENT);
        end
        default: begin
          if (ps_left > 0) ps_left = ps_left - 32'd1;
          case (ps_phase)
            PH_FTYPE: begin
              if (word_done(b)) begin
                if (ps_word != FT_CONTENT) begin
                  ps_match = MS_FAIL;
                  ps_phase = PH_SKIP;
                end else begin
                  ps_phase = PH_FLEN;
                end
                ps_word = '0;
              end
            end
            PH_FLEN: begin
              if (word_done(b)) begin
                if (ps_word > ps_left) begin
                  ps_match = MS_FAIL;
                  ps_phase = PH_SKIP;
                end else begin
                  ps_field = ps_word;
                  ps_id_eq = (ps_word == ID_LEN);
                  ps_idx = '0;
                  if (ps_field == 0) next_fld = 1'b1;
                  else ps_phase = PH_BODY;
                end
                ps_word = '0;
              end
            end
            PH_BODY: begin
              if (ps_id_eq) begin
                if (ps_idx < ID_LEN && b == dnstap_char(ps_idx)) ps_idx = ps_idx + 5'd1;
                else ps_id_eq = 1'b0;
              end
              if (ps_field > 0) ps_field = ps_field - 32'd1;
              if (ps_field == 0) begin
                if (ps_id_eq) begin
                  ps_match = MS_MATCH;
                  ps_phase = PH_SKIP;
                end else begin
                  next_fld = 1'b1;
                end
              end
            end
            default: ps_phase = PH_SKIP;
          endcase
          if (ps_left == 0) close_control();
          else if (next_fld) open_field();
        end
      endcase
    end
  endtask

  // ---------------- stream side ----------------

  always @(posedge clk) begin
    if (rst) begin
      stream_in.valid <= 1'b0;
      stream_in.rx_byte <= 8'd0;
    end else if (!stream_in.valid || stream_in.ready) begin
      if (stream_bytes_q.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
        stream_in.valid <= 1'b1;
        stream_in.rx_byte <= stream_bytes_q.pop_front();
      end else begin
        stream_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result_out.ready <= 1'b0;
    else result_out.ready <= !hold_off && (steady || $urandom_range(0, 99) >= 27);
  end

  initial begin
    wait (run_stage == 3);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (240) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------- result checking ----------------

  task automatic log_fault(input string what, input beat_t want, input beat_t got);
    if (fault_count < 10) begin
      $display("%0t %s: expected kind %0d byte %02h last %0b code %0d started %0b",
               $time, what, want.kind, want.data, want.last, want.code, want.started);
      $display("%0t %s: actual   kind %0d byte %02h last %0b code %0d started %0b",
               $time, what, got.kind, got.data, got.last, got.code, got.started);
    end
    fault_count++;
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      ps_phase = PH_LEN;
      ps_word = '0;
      ps_left = '0;
      ps_field = '0;
      ps_kind = CK_OTHER;
      ps_idx = '0;
      ps_match = MS_SEARCH;
      ps_started = 1'b0;
      ps_halted = 1'b0;
      ps_id_eq = 1'b0;
      ps_max = CFG_W'(MAX_CTL_RST);
    end else begin
      if (cfg_wr_en) ps_max = cfg_wr_data;
      if (stream_in.valid && stream_in.ready) parse_stream_byte(stream_in.rx_byte);
      if (result_out.valid && result_out.ready) begin
        got = {result_out.kind, result_out.out_byte, result_out.last,
               result_out.event_code, result_out.started_now};
        if (parser_out_q.size() == 0) begin
          log_fault("unexpected beat", '0, got);
        end else begin
          want = parser_out_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
              got.code !== want.code || got.started !== want.started) begin
            log_fault("wrong beat", want, got);
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_stream(input logic [7:0] b);
    stream_bytes_q.push_back(b);
    stream_len++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_stream(w[8*i +: 8]);
  endtask

  task automatic body_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) body_q.push_back(w[8*i +: 8]);
  endtask

  task automatic body_random(input int n);
    for (int i = 0; i < n; i++) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic body_id(input int n, input int flip_at, input logic [7:0] mask);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = dnstap_char(i);
      if (i == flip_at) c = c ^ mask;
      body_q.push_back(c);
    end
  endtask

  task automatic send_data_frame(input int n, input int fill);
    send_word(n);
    for (int i = 0; i < n; i++) push_stream(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  task automatic send_control(input logic [31:0] ctype);
    send_word(0);
    send_word(4 + body_q.size());
    send_word(ctype);
    while (body_q.size() != 0) push_stream(body_q.pop_front());
  endtask

  task automatic build_payload(input int variant);
    int k;
    logic [31:0] w;
    case (variant)
      1, 8, 9: begin
        body_word(FT_CONTENT);
        body_word(ID_LEN);
        body_id(ID_LEN, -1, 8'd0);
        body_random($urandom_range(0, 2));
      end
      2: begin
        body_word(FT_CONTENT);
        body_word(ID_LEN);
        body_id(ID_LEN, $urandom_range(0, ID_LEN - 1), 8'(1 << $urandom_range(0, 7)));
      end
      3: begin
        body_word(FT_CONTENT);
        body_word(0);
        body_word(FT_CONTENT);
        body_word(ID_LEN);
        body_id(ID_LEN, -1, 8'd0);
        body_random($urandom_range(0, 3));
      end
      4: begin
        w = $urandom;
        if (w == FT_CONTENT) w = 32'd0;
        body_word(w);
        body_word($urandom_range(0, 30));
        body_random($urandom_range(1, 6));
      end
      5: begin
        k = $urandom_range(1, 5);
        body_word(FT_CONTENT);
        body_word($urandom_range(0, 1) ? 32'(k + 1) : ($urandom | 32'h8000_0000));
        body_random(k);
      end
      6: body_random($urandom_range(1, 8));
      7: begin
        k = $urandom_range(1, 6);
        body_word(FT_CONTENT);
        body_word(k);
        body_random(k);
        body_word(FT_CONTENT);
        body_word(ID_LEN);
        body_id(ID_LEN, -1, 8'd0);
      end
      default: ;
    endcase
  endtask

  task automatic send_random_frame(input int limit);
    int pick;
    logic [31:0] ctype;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      send_data_frame(($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(1, 6), -1);
    end else begin
      case (pick)
        4, 5:    ctype = CT_READY;
        6, 7:    ctype = CT_START;
        8:       ctype = CT_STOP;
        default: ctype = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 7));
      endcase
      build_payload($urandom_range(0, 9));
      if (4 + body_q.size() > limit) body_q.delete();
      send_control(ctype);
    end
  endtask

  task automatic send_random_bytes(input int budget, input int limit);
    int start;
    start = stream_len;
    while (stream_len - start < budget) send_random_frame(limit);
  endtask

  task automatic write_max_len(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (stream_bytes_q.size() != 0 || stream_in.valid || parser_out_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] lim;
    logic [31:0] clen;
    stream_in.valid = 1'b0;
    stream_in.rx_byte = 8'd0;
    result_out.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    steady = 1'b0;
    hold_off = 1'b0;
    run_stage = 0;
    fault_count = 0;
    stream_len = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_max_len(CFG_W'(MAX_CTL_RST));
    send_data_frame(3, -1);
    build_payload(1);
    send_control(CT_READY);
    send_control(CT_READY);
    body_word(FT_CONTENT);
    body_word(32'hFFFF_FFFF);
    body_random(2);
    send_control(CT_START);
    build_payload(3);
    send_control(CT_START);
    send_data_frame(5, 8'hFF);
    send_control(CT_STOP);
    send_data_frame(2, -1);
    wait_drained();

    write_max_len(CFG_W'(4));
    run_stage = 1;
    send_random_bytes(12, 4);
    wait_drained();

    lim = CFG_W'($urandom_range(34, 100));
    write_max_len(lim);
    run_stage = 2;
    steady <= 1'b1;
    send_random_bytes(30, lim);
    wait_drained();
    steady <= 1'b0;

    write_max_len(CFG_W'(MAX_CTL_RST));
    run_stage = 3;
    send_random_bytes(20, MAX_CTL_RST);
    // a STOP event late in the stage, with data bytes behind it that the stopped stream drops
    send_control(CT_STOP);
    send_data_frame(4, -1);
    wait_drained();

    // length error halts the block, trailing bytes are swallowed
    run_stage = 4;
    case ($urandom_range(0, 2))
      0: clen = 32'($urandom_range(0, 3));
      1: begin
        lim = CFG_W'($urandom_range(4, 60));
        write_max_len(lim);
        clen = $urandom_range(0, 1) ? 32'(lim) + 32'd1 : ($urandom | 32'h8000_0000);
      end
      default: begin
        write_max_len(CFG_W'($urandom_range(0, 3)));
        clen = 32'($urandom_range(0, 40));
      end
    endcase
    send_word(0);
    send_word(clen);
    for (int i = 0; i < 12; i++) push_stream(8'($urandom_range(0, 255)));
    wait_drained();

    if (fault_count == 0 && parser_out_q.size() == 0) begin
      $display("frame_stream_receiver: match");
    end else begin
      $display("frame_stream_receiver: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_in_if.sv
hw/rtl/fsr_out_if.sv
hw/rtl/fsr_parser.sv
hw/rtl/fsr_out_stage.sv
hw/rtl/frame_stream_receiver.sv
hw/rtl/fsr_checker.sv
sim/frame_stream_receiver_tb.sv
